### hw/rtl/polar_sector_neighbour_enumerator_macros.svh
// ----------------------------------------------------------------------------
// polar sector neighbour enumerator assertion macros
// shared concurrent assertion forms, compiled out when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef POLAR_SECTOR_NEIGHBOUR_ENUMERATOR_MACROS_SVH
`define POLAR_SECTOR_NEIGHBOUR_ENUMERATOR_MACROS_SVH

`ifndef ASSERT_OFF

// property that holds in the same cycle once out of reset
`define PSNE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// property whose consequence holds in the cycle after the antecedent
`define PSNE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define PSNE_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define PSNE_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### hw/rtl/psne_pkg.sv
// ----------------------------------------------------------------------------
// psne_pkg
// widths, codes and controller/datapath interface types of the polar sector
// neighbour enumerator
// ----------------------------------------------------------------------------
package psne_pkg;

    localparam int MAX_SCALE = 7;
    localparam int SCALE_W   = 3;
    localparam int RING_W    = 5;
    localparam int SECTOR_W  = 7;
    localparam int STEP_W    = 6;
    localparam int TDATA_W   = 16;

    // special sector codes at ring 0
    localparam logic signed [SECTOR_W-1:0] SEC_SAME   = -7'sd2;
    localparam logic signed [SECTOR_W-1:0] SEC_DOUBLE = -7'sd1;
    localparam logic signed [SECTOR_W-1:0] SEC_TRIPLE = 7'sd0;

    // steps of a general relation's neighbour list
    localparam logic [STEP_W-1:0] STEP_IN_PREV  = 6'd0;
    localparam logic [STEP_W-1:0] STEP_IN_SAME  = 6'd1;
    localparam logic [STEP_W-1:0] STEP_IN_NEXT  = 6'd2;
    localparam logic [STEP_W-1:0] STEP_AT_PREV  = 6'd3;
    localparam logic [STEP_W-1:0] STEP_AT_NEXT  = 6'd4;
    localparam logic [STEP_W-1:0] STEP_OUT_PREV = 6'd5;
    localparam logic [STEP_W-1:0] STEP_OUT_SAME = 6'd6;
    localparam logic [STEP_W-1:0] STEP_OUT_NEXT = 6'd7;

    // steps of the triple list
    localparam logic [STEP_W-1:0] STEP_TRI_DOUBLE = 6'd0;
    localparam logic [STEP_W-1:0] STEP_TRI_SAME   = 6'd1;
    localparam logic [STEP_W-1:0] STEP_TRI_FAR    = 6'd2;

    typedef enum logic [1:0] {
        KIND_EMPTY,
        KIND_TRIPLE,
        KIND_RINGWIDE,
        KIND_GENERAL
    } psne_kind_t;

    typedef struct packed {
        logic load;
        logic emit;
    } psne_cmd_t;

    typedef struct packed {
        logic out_free;
        logic at_last;
    } psne_status_t;

    // granularity in use for a register value
    function automatic logic [SCALE_W-1:0] sat_scale(input logic [SCALE_W-1:0] s);
        logic [SCALE_W-1:0] r;
        r = (int'(s) > MAX_SCALE) ? SCALE_W'(MAX_SCALE) : s;
        return r;
    endfunction

endpackage

### hw/rtl/polar_sector_neighbour_enumerator.sv
// ----------------------------------------------------------------------------
// polar_sector_neighbour_enumerator
// lists the neighbour relations of one polar sector grid relation
// ----------------------------------------------------------------------------
// One relation beat in gives its neighbours as a run of result beats, one per
// cycle while the result side takes them, closed by tlast. A general relation
// gives up to eight beats, the triple code three, the same and double codes
// 8m+1, an invalid relation one beat with tuser set. The step counter of the
// datapath advances one beat per cycle while the output register is free, and
// the next relation is taken in the cycle that the last beat of a run is
// registered. Scale is written through cfg_wr_en / cfg_wr_data; the user
// must write it only while the block is idle, the block does not enforce it.
// ----------------------------------------------------------------------------
`include "polar_sector_neighbour_enumerator_macros.svh"

module polar_sector_neighbour_enumerator (
    input  logic                           aclk,
    input  logic                           aresetn,
    // scale register write
    input  logic                           cfg_wr_en,
    input  logic [psne_pkg::SCALE_W-1:0]   cfg_wr_data,
    // relation beats
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [psne_pkg::TDATA_W-1:0]   s_tdata,  // [4:0] ring_index, [11:5] sector_index
    // neighbour beats
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [psne_pkg::TDATA_W-1:0]   m_tdata,  // [4:0] neighbour_ring, [11:5] neighbour_sector
    output logic                           m_tuser,  // [0] empty_res
    output logic                           m_tlast
);
    import psne_pkg::*;

    // scale register
    logic [SCALE_W-1:0] scale_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg <= SCALE_W'(2);
        end else if (cfg_wr_en) begin
            scale_reg <= cfg_wr_data;
        end
    end

    psne_cmd_t                  cmd;
    psne_status_t               status;
    logic [RING_W-1:0]          out_ring;
    logic signed [SECTOR_W-1:0] out_sector;

    psne_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    psne_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .scale      (scale_reg),
        .in_ring    (s_tdata[RING_W-1:0]),
        .in_sector  (s_tdata[RING_W+SECTOR_W-1:RING_W]),
        .cmd        (cmd),
        .status     (status),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_ring   (out_ring),
        .out_sector (out_sector),
        .out_empty  (m_tuser),
        .out_last   (m_tlast)
    );

    assign m_tdata = {{(TDATA_W-RING_W-SECTOR_W){1'b0}}, out_sector, out_ring};

    // an invalid relation is a single beat with zero fields
    `PSNE_ASSERT_NOW(a_empty_is_last, aclk, aresetn, m_tvalid && m_tuser, m_tlast)
    `PSNE_ASSERT_NOW(a_empty_zero, aclk, aresetn, m_tvalid && m_tuser, m_tdata == '0)
    // an emitted neighbour shows up as a valid beat
    `PSNE_ASSERT_NEXT(a_emit_valid, aclk, aresetn, cmd.emit, m_tvalid)

endmodule

### hw/rtl/psne_ctrl.sv
// ----------------------------------------------------------------------------
// psne_ctrl
// controller: takes a relation, then steps the datapath through its list,
// one neighbour beat per cycle while the output register is free
// ----------------------------------------------------------------------------
module psne_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  psne_pkg::psne_status_t status,
    output psne_pkg::psne_cmd_t   cmd
);
    import psne_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t state_reg, state_next;
    logic   emit;
    logic   load;

    // command decode
    always_comb begin
        emit = (state_reg == ST_RUN) && status.out_free;
        in_ready = (state_reg == ST_IDLE) || (emit && status.at_last);
        load = in_valid && in_ready;
        cmd.load = load;
        cmd.emit = emit;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (load) state_next = ST_RUN;
            end
            ST_RUN: begin
                if (emit && status.at_last && !load) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### hw/rtl/psne_datapath.sv
// ----------------------------------------------------------------------------
// psne_datapath
// relation registers, classification, step counter, neighbour select and
// the output register of the result stream
// ----------------------------------------------------------------------------
module psne_datapath (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic [psne_pkg::SCALE_W-1:0]          scale,
    input  logic [psne_pkg::RING_W-1:0]           in_ring,
    input  logic signed [psne_pkg::SECTOR_W-1:0]  in_sector,
    input  psne_pkg::psne_cmd_t                   cmd,
    output psne_pkg::psne_status_t                status,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [psne_pkg::RING_W-1:0]           out_ring,
    output logic signed [psne_pkg::SECTOR_W-1:0]  out_sector,
    output logic                                  out_empty,
    output logic                                  out_last
);
    import psne_pkg::*;

    // classification of the incoming relation
    logic [SCALE_W-1:0]  m_in;
    logic [RING_W-1:0]   four_m_in;
    logic [STEP_W-1:0]   eight_m_in;
    logic [STEP_W-1:0]   sec_lo;
    logic                ring_ok;
    logic                is_special;
    psne_kind_t          kind_in;
    logic [STEP_W-1:0]   prev_in;
    logic [STEP_W-1:0]   next_in;
    logic [STEP_W-1:0]   first_in;
    logic [STEP_W-1:0]   final_in;
    logic [RING_W-1:0]   outer_in;

    always_comb begin
        m_in       = sat_scale(scale);
        four_m_in  = {m_in, 2'b00};
        eight_m_in = {m_in, 3'b000};
        sec_lo     = in_sector[STEP_W-1:0];
        ring_ok    = in_ring < four_m_in;
        is_special = (in_sector == SEC_SAME) || (in_sector == SEC_DOUBLE)
                     || (in_sector == SEC_TRIPLE);
        if (!ring_ok) begin
            kind_in = KIND_EMPTY;
        end else if (in_ring == '0) begin
            if (in_sector == SEC_TRIPLE)  kind_in = KIND_TRIPLE;
            else if (is_special)          kind_in = KIND_RINGWIDE;
            else                          kind_in = KIND_EMPTY;
        end else if (!in_sector[SECTOR_W-1] && (sec_lo != '0) && (sec_lo <= eight_m_in)) begin
            kind_in = KIND_GENERAL;
        end else begin
            kind_in = KIND_EMPTY;
        end
        // wrapped neighbours in orientation
        prev_in  = (sec_lo == 6'd1) ? eight_m_in : sec_lo - 6'd1;
        next_in  = (sec_lo == eight_m_in) ? 6'd1 : sec_lo + 6'd1;
        // ring-wide lists run out on the outermost ring for double, ring 1 for same
        outer_in = (in_sector == SEC_DOUBLE) ? four_m_in - 5'd1 : 5'd1;
        // first and final step of the list
        first_in = '0;
        unique case (kind_in)
            KIND_EMPTY:    final_in = '0;
            KIND_TRIPLE:   final_in = STEP_TRI_FAR;
            KIND_RINGWIDE: final_in = eight_m_in;
            KIND_GENERAL: begin
                if (in_ring == 5'd1) first_in = STEP_IN_NEXT;
                final_in = ((in_ring + 5'd1) == four_m_in) ? STEP_AT_NEXT : STEP_OUT_NEXT;
            end
            default:       final_in = '0;
        endcase
    end

    // relation registers
    psne_kind_t         kind_reg;
    logic [SCALE_W-1:0] m_reg;
    logic [RING_W-1:0]  ring_reg;
    logic [STEP_W-1:0]  sec_reg;
    logic [STEP_W-1:0]  prev_reg;
    logic [STEP_W-1:0]  next_reg;
    logic [RING_W-1:0]  outer_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [STEP_W-1:0]  final_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg  <= kind_in;
            m_reg     <= m_in;
            ring_reg  <= in_ring;
            sec_reg   <= sec_lo;
            prev_reg  <= prev_in;
            next_reg  <= next_in;
            outer_reg <= outer_in;
            final_reg <= final_in;
        end
    end

    // step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
        end else if (cmd.load) begin
            step_reg <= first_in;
        end else if (cmd.emit) begin
            step_reg <= step_reg + 6'd1;
        end
    end

    // neighbour of the current step
    logic [RING_W-1:0]          nb_ring;
    logic signed [SECTOR_W-1:0] nb_sector;
    logic                       nb_empty;
    logic [RING_W-1:0]          ring_in_side;
    logic [RING_W-1:0]          ring_out_side;

    always_comb begin
        ring_in_side  = ring_reg - 5'd1;
        ring_out_side = ring_reg + 5'd1;
        nb_ring   = '0;
        nb_sector = '0;
        nb_empty  = 1'b0;
        unique case (kind_reg)
            KIND_EMPTY: begin
                nb_empty = 1'b1;
            end
            KIND_TRIPLE: begin
                unique case (step_reg)
                    STEP_TRI_DOUBLE: nb_sector = SEC_DOUBLE;
                    STEP_TRI_SAME:   nb_sector = SEC_SAME;
                    default: begin
                        nb_ring   = {1'b0, m_reg, 1'b0} - 5'd1;
                        nb_sector = {2'b00, m_reg, 2'b01};
                    end
                endcase
            end
            KIND_RINGWIDE: begin
                if (step_reg != '0) begin
                    nb_ring   = outer_reg;
                    nb_sector = {1'b0, step_reg};
                end
            end
            KIND_GENERAL: begin
                unique case (step_reg)
                    STEP_IN_PREV: begin
                        nb_ring = ring_in_side;  nb_sector = {1'b0, prev_reg};
                    end
                    STEP_IN_SAME: begin
                        nb_ring = ring_in_side;  nb_sector = {1'b0, sec_reg};
                    end
                    STEP_IN_NEXT: begin
                        // ring 1 sees the center as a single neighbour
                        if (ring_reg == 5'd1) begin
                            nb_ring = '0;  nb_sector = SEC_SAME;
                        end else begin
                            nb_ring = ring_in_side;  nb_sector = {1'b0, next_reg};
                        end
                    end
                    STEP_AT_PREV: begin
                        nb_ring = ring_reg;  nb_sector = {1'b0, prev_reg};
                    end
                    STEP_AT_NEXT: begin
                        nb_ring = ring_reg;  nb_sector = {1'b0, next_reg};
                    end
                    STEP_OUT_PREV: begin
                        nb_ring = ring_out_side;  nb_sector = {1'b0, prev_reg};
                    end
                    STEP_OUT_SAME: begin
                        nb_ring = ring_out_side;  nb_sector = {1'b0, sec_reg};
                    end
                    default: begin
                        nb_ring = ring_out_side;  nb_sector = {1'b0, next_reg};
                    end
                endcase
            end
            default: nb_empty = 1'b1;
        endcase
    end

    // output register
    logic                       out_valid_reg;
    logic [RING_W-1:0]          out_ring_reg;
    logic signed [SECTOR_W-1:0] out_sector_reg;
    logic                       out_empty_reg;
    logic                       out_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_ring_reg   <= nb_ring;
            out_sector_reg <= nb_sector;
            out_empty_reg  <= nb_empty;
            out_last_reg   <= status.at_last;
        end
    end

    assign status.out_free = !out_valid_reg || out_ready;
    assign status.at_last  = (step_reg == final_reg);

    assign out_valid  = out_valid_reg;
    assign out_ring   = out_ring_reg;
    assign out_sector = out_sector_reg;
    assign out_empty  = out_empty_reg;
    assign out_last   = out_last_reg;

endmodule

### verif/tb_polar_sector_neighbour_enumerator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_polar_sector_neighbour_enumerator
// self-checking bench for the polar sector neighbour enumerator
// ----------------------------------------------------------------------------
// Relation beats go in on the s_ side and every neighbour beat that comes out
// on the m_ side is compared with a neighbour list worked out in the bench
// for the scale in force. The bench walks the special ring 0 codes, sector
// wrap, the inner and outer rings and invalid relations, then sends random
// relations under a range of scales, with random gaps on the sending side and
// random stalls on the receiving side.
// ----------------------------------------------------------------------------
module tb_polar_sector_neighbour_enumerator;

    import psne_pkg::*;

    localparam int CLK_HALF    = 6;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int ITEMS_PER_SCALE = 38;

    typedef struct {
        logic [RING_W-1:0]          ring;
        logic signed [SECTOR_W-1:0] sector;
        logic                       empty;
        logic                       last;
    } nbr_beat_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [SCALE_W-1:0]   cfg_wr_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [TDATA_W-1:0]   s_tdata;   // [4:0] ring_index, [11:5] sector_index
    logic                 m_tvalid;
    logic                 m_tready;
    logic [TDATA_W-1:0]   m_tdata;   // [4:0] neighbour_ring, [11:5] neighbour_sector
    logic                 m_tuser;   // [0] empty_res
    logic                 m_tlast;

    // bench copy of the scale register
    logic [SCALE_W-1:0]   scale_cfg;
    // neighbour beats still owed by the block, oldest first
    nbr_beat_t            owed_nbrs[$];
    nbr_beat_t            staged_nbrs[$];
    bit                   idle_en;
    int                   fail_count;
    int                   cycle_count;

    polar_sector_neighbour_enumerator u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    // run length guard
    initial cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // gap or stall length: mostly none or short, now and then long
    function automatic int idle_len();
        int pick;
        if (!idle_en)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 20);
    endfunction

    function automatic void stage_nbr(input int ring, input int sector, input bit empty);
        nbr_beat_t b;
        b.ring   = RING_W'(ring);
        b.sector = SECTOR_W'(sector);
        b.empty  = empty;
        b.last   = 1'b0;
        staged_nbrs.insert(staged_nbrs.size(), b);
    endfunction

    // neighbour list of one relation at the current scale
    function automatic void predict_neighbours(input logic [RING_W-1:0] ring,
                                               input logic signed [SECTOR_W-1:0] sec);
        int m, r, q, top_ring, top_sec, prev, next, outer, s;
        bit ok;
        m        = (int'(scale_cfg) > MAX_SCALE) ? MAX_SCALE : int'(scale_cfg);
        r        = int'(ring);
        q        = sec;
        top_ring = 4 * m - 1;
        top_sec  = 8 * m;
        staged_nbrs.delete();

        if (r > top_ring)
            ok = 1'b0;
        else if (r == 0)
            ok = (sec == SEC_SAME) || (sec == SEC_DOUBLE) || (sec == SEC_TRIPLE);
        else
            ok = (q >= 1) && (q <= top_sec);

        if (!ok) begin
            stage_nbr(0, 0, 1'b1);
        end else if (r == 0 && sec == SEC_TRIPLE) begin
            stage_nbr(0, SEC_DOUBLE, 1'b0);
            stage_nbr(0, SEC_SAME, 1'b0);
            stage_nbr(2 * m - 1, 4 * m + 1, 1'b0);
        end else if (r == 0) begin
            // same and double codes list a whole ring
            outer = (sec == SEC_DOUBLE) ? top_ring : 1;
            stage_nbr(0, SEC_TRIPLE, 1'b0);
            for (s = 1; s <= top_sec; s++)
                stage_nbr(outer, s, 1'b0);
        end else begin
            prev = (q == 1) ? top_sec : q - 1;
            next = (q == top_sec) ? 1 : q + 1;
            if (r == 1) begin
                stage_nbr(0, SEC_SAME, 1'b0);
            end else begin
                stage_nbr(r - 1, prev, 1'b0);
                stage_nbr(r - 1, q, 1'b0);
                stage_nbr(r - 1, next, 1'b0);
            end
            stage_nbr(r, prev, 1'b0);
            stage_nbr(r, next, 1'b0);
            if (r < top_ring) begin
                stage_nbr(r + 1, prev, 1'b0);
                stage_nbr(r + 1, q, 1'b0);
                stage_nbr(r + 1, next, 1'b0);
            end
        end

        staged_nbrs[staged_nbrs.size() - 1].last = 1'b1;
        foreach (staged_nbrs[i])
            owed_nbrs.insert(owed_nbrs.size(), staged_nbrs[i]);
    endfunction

    // one relation beat; s_tvalid stays high when the next beat follows at once
    task automatic send_relation(input logic [RING_W-1:0] ring,
                                 input logic signed [SECTOR_W-1:0] sec);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        predict_neighbours(ring, sec);
        s_tvalid <= 1'b1;
        s_tdata  <= {{(TDATA_W - RING_W - SECTOR_W){1'b0}}, sec, ring};
        do
            @(posedge aclk);
        while (!s_tready);
    endtask

    // stop sending and wait for every owed beat
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (owed_nbrs.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_scale(input logic [SCALE_W-1:0] val);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        scale_cfg    = val;
    endtask

    // result side ready with random stalls
    initial begin : sink_ready
        int hold;
        hold = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold > 0) begin
                m_tready <= 1'b0;
                hold--;
            end else begin
                m_tready <= 1'b1;
                hold = idle_len();
            end
        end
    end

    // compare each neighbour beat with the oldest owed one
    always @(posedge aclk) begin : beat_check
        nbr_beat_t want;
        logic [TDATA_W-1:0] want_data;
        if (aresetn && m_tvalid && m_tready) begin
            if (owed_nbrs.size() == 0) begin
                if (fail_count < 10)
                    $display("unexpected beat: tdata %h tuser %b tlast %b",
                             m_tdata, m_tuser, m_tlast);
                fail_count++;
            end else begin
                want      = owed_nbrs.pop_front();
                want_data = {{(TDATA_W - RING_W - SECTOR_W){1'b0}}, want.sector, want.ring};
                if (m_tdata !== want_data || m_tuser !== want.empty
                        || m_tlast !== want.last) begin
                    if (fail_count < 10) begin
                        $display("mismatch: ring exp %0d got %0d, sector exp %0d got %0d,",
                                 want.ring, m_tdata[RING_W-1:0],
                                 want.sector, $signed(m_tdata[RING_W+SECTOR_W-1:RING_W]));
                        $display("  empty exp %b got %b, last exp %b got %b, pad got %h",
                                 want.empty, m_tuser, want.last, m_tlast,
                                 m_tdata[TDATA_W-1:RING_W+SECTOR_W]);
                    end
                    fail_count++;
                end
            end
        end
    end

    // special codes, wrap and edge rings at the reset scale of two
    task automatic test_reset_scale_lists();
        idle_en = 1'b0;
        send_relation(5'd0, SEC_SAME);
        send_relation(5'd0, SEC_DOUBLE);
        send_relation(5'd0, SEC_TRIPLE);
        send_relation(5'd0, 7'sd1);       // ring 0 with a plain sector
        send_relation(5'd0, -7'sd3);      // ring 0 with an unknown code
        send_relation(5'd1, 7'sd1);       // wrap to the top sector
        send_relation(5'd1, 7'sd16);      // wrap to sector one
        send_relation(5'd1, 7'sd0);       // sector below range
        send_relation(5'd1, 7'sd17);      // sector above range
        send_relation(5'd7, 7'sd8);       // outermost ring
        send_relation(5'd7, 7'sd16);
        send_relation(5'd8, 7'sd1);       // ring above range
        send_relation(5'd31, -7'sd64);
        send_relation(5'd3, 7'sd63);
        send_relation(5'd2, 7'sd5);
    endtask

    // largest, smallest and zero scale
    task automatic test_scale_extremes();
        idle_en = 1'b1;
        write_scale(SCALE_W'(MAX_SCALE));
        send_relation(5'd27, 7'sd56);
        send_relation(5'd0, SEC_DOUBLE);
        send_relation(5'd27, 7'sd1);
        write_scale(3'd1);
        send_relation(5'd3, 7'sd8);
        send_relation(5'd0, SEC_TRIPLE);
        send_relation(5'd1, 7'sd4);
        // no valid ring at scale zero
        write_scale(3'd0);
        send_relation(5'd0, SEC_TRIPLE);
        send_relation(5'd0, SEC_SAME);
        send_relation(5'd5, 7'sd3);
    endtask

    // random relations, mostly well formed, under every scale
    task automatic test_random_relations();
        logic [SCALE_W-1:0] scales[8];
        logic [RING_W-1:0] ring;
        logic signed [SECTOR_W-1:0] sec;
        int m, pick, k;
        scales = '{3'd1, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7, 3'd0, 3'd2};
        foreach (scales[p]) begin
            write_scale(scales[p]);
            idle_en = (p != 2);
            m = int'(scales[p]);
            for (k = 0; k < ITEMS_PER_SCALE; k++) begin
                pick = $urandom_range(0, 99);
                if (m == 0 || pick >= 82) begin
                    ring = RING_W'($urandom());
                    sec  = SECTOR_W'($urandom());
                end else if (pick < 6) begin
                    ring = '0;
                    case ($urandom_range(0, 2))
                        0: sec = SEC_SAME;
                        1: sec = SEC_DOUBLE;
                        default: sec = SEC_TRIPLE;
                    endcase
                end else begin
                    ring = RING_W'($urandom_range(1, 4 * m - 1));
                    sec  = SECTOR_W'($urandom_range(1, 8 * m));
                end
                send_relation(ring, sec);
            end
        end
    endtask

    // main sequence
    initial begin
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        scale_cfg    = 3'd2;
        idle_en      = 1'b0;
        fail_count   = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_scale_lists();
        test_scale_extremes();
        test_random_relations();

        drain_results();
        repeat (8) @(posedge aclk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
